### rtl/tsv_row_field_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// tsv_row_field_tokenizer_defines.svh
// Assertion macros for the TSV field tokenizer.
// ----------------------------------------------------------------------------
`ifndef TSV_ROW_FIELD_TOKENIZER_DEFINES_SVH
`define TSV_ROW_FIELD_TOKENIZER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define TSVFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define TSVFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tsvft_pkg.sv
// ----------------------------------------------------------------------------
// tsvft_pkg
// Shared types and constants of the TSV field tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsvft_pkg;

    localparam logic [7:0] TAB_BYTE     = 8'd9;
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    localparam int ITEM_QUEUE_DEPTH   = 2;
    localparam int RESULT_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic is_tab;
        logic is_nl;
        logic eod;
    } t_item;

    typedef struct packed {
        logic [31:0] row_number;
        logic [7:0]  column_number;
        logic [31:0] field_offset;
        logic [31:0] field_length;
        logic        row_done;
        logic        row_accepted;
        logic [8:0]  columns_per_row;
    } t_result;

    typedef struct packed {
        logic stopped;
        logic header;
    } t_back_status;

endpackage

`default_nettype wire

### rtl/tsvft_fifo.sv
// ----------------------------------------------------------------------------
// tsvft_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tsvft_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/tsvft_front.sv
// ----------------------------------------------------------------------------
// tsvft_front
// Byte classifier and item queue feeding the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module tsvft_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_end_of_data,
    output tsvft_pkg::t_item    o_item,
    output logic                o_item_empty,
    input  wire logic           i_item_pop
);

    tsvft_pkg::t_item w_item;
    logic [$bits(tsvft_pkg::t_item)-1:0] w_q_out;

    always_comb begin
        w_item.is_tab = (i_data_byte == tsvft_pkg::TAB_BYTE);
        w_item.is_nl  = (i_data_byte == tsvft_pkg::NEWLINE_BYTE);
        w_item.eod    = i_end_of_data;
    end

    tsvft_fifo #(
        .WIDTH ($bits(tsvft_pkg::t_item)),
        .DEPTH (tsvft_pkg::ITEM_QUEUE_DEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_item),
        .o_full  (full),
        .i_pop   (i_item_pop),
        .o_data  (w_q_out),
        .o_empty (o_item_empty)
    );

    assign o_item = tsvft_pkg::t_item'(w_q_out);

endmodule

`default_nettype wire

### rtl/tsvft_back.sv
// ----------------------------------------------------------------------------
// tsvft_back
// Row/column parser and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tsvft_back #(
    parameter int MAX_COLUMNS = 256,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tsvft_pkg::t_item  i_item,
    input  wire logic              i_item_empty,
    output logic                   o_item_pop,
    output tsvft_pkg::t_result     o_res,
    output logic                   o_res_empty,
    input  wire logic              i_res_pop,
    output tsvft_pkg::t_back_status o_status
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_BODY    = 3'b010,
        PH_STOPPED = 3'b100
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [CW-1:0]          r_col, n_col;
    logic [CW-1:0]          r_total, n_total;
    logic [31:0]            r_row, n_row;

    logic [OFFSET_BITS-1:0] w_len, w_next, w_emit_len;
    logic [CW:0]            w_col_inc;
    logic                   w_res_full, w_fire, w_emit, w_done, w_acc;
    logic                   w_header, w_running, w_too_many, w_bad_nl;
    tsvft_pkg::t_result     w_res;
    logic [$bits(tsvft_pkg::t_result)-1:0] w_res_q;

    assign w_fire     = !i_item_empty && !w_res_full;
    assign o_item_pop = w_fire;

    assign w_len     = r_pos - r_start;
    assign w_next    = r_pos + OFFSET_BITS'(1);
    assign w_col_inc = {1'b0, r_col} + (CW + 1)'(1);
    assign w_header  = (r_phase == PH_HEADER);
    assign w_running = (r_phase == PH_HEADER) || (r_phase == PH_BODY);

    always_comb begin
        w_too_many = w_header ? (w_col_inc >= (CW + 1)'(MAX_COLUMNS))
                              : (w_col_inc >= {1'b0, r_total});
        w_bad_nl   = ((r_col != '0) && (w_len == '0))
                     || (!w_header && (w_col_inc != {1'b0, r_total}));
    end

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_start    = r_start;
        n_col      = r_col;
        n_total    = r_total;
        n_row      = r_row;
        w_emit     = 1'b0;
        w_done     = 1'b0;
        w_acc      = 1'b0;
        w_emit_len = w_len;
        if (w_fire && w_running) begin
            if (i_item.is_tab) begin
                w_emit = 1'b1;
                if (w_too_many || i_item.eod) begin
                    w_done  = 1'b1;
                    n_phase = PH_STOPPED;
                end else begin
                    n_col   = CW'(w_col_inc);
                    n_start = w_next;
                    n_pos   = w_next;
                end
            end else if (i_item.is_nl) begin
                w_emit = 1'b1;
                w_done = 1'b1;
                if (w_bad_nl) begin
                    n_phase = PH_STOPPED;
                end else begin
                    w_acc = 1'b1;
                    if (w_header) begin
                        n_total = CW'(w_col_inc);
                    end
                    n_row   = r_row + 32'd1;
                    n_col   = '0;
                    n_start = w_next;
                    n_pos   = w_next;
                    n_phase = i_item.eod ? PH_STOPPED : PH_BODY;
                end
            end else if (i_item.eod) begin
                w_emit     = 1'b1;
                w_done     = 1'b1;
                w_emit_len = w_len + OFFSET_BITS'(1);
                n_phase    = PH_STOPPED;
            end else begin
                n_pos = w_next;
            end
        end
    end

    // the header's closing newline already reports the learned column count
    always_comb begin
        w_res.row_number      = r_row;
        w_res.column_number   = 8'(r_col);
        w_res.field_offset    = 32'(r_start);
        w_res.field_length    = 32'(w_emit_len);
        w_res.row_done        = w_done;
        w_res.row_accepted    = w_acc;
        w_res.columns_per_row = 9'(n_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_start <= '0;
            r_col   <= '0;
            r_total <= '0;
            r_row   <= '0;
        end else begin
            case (r_phase)
                PH_HEADER, PH_BODY, PH_STOPPED: begin
                    r_phase <= n_phase;
                end
                default: begin
                    r_phase <= PH_STOPPED;
                end
            endcase
            r_pos   <= n_pos;
            r_start <= n_start;
            r_col   <= n_col;
            r_total <= n_total;
            r_row   <= n_row;
        end
    end

    tsvft_fifo #(
        .WIDTH ($bits(tsvft_pkg::t_result)),
        .DEPTH (tsvft_pkg::RESULT_QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_emit),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (i_res_pop),
        .o_data  (w_res_q),
        .o_empty (o_res_empty)
    );

    assign o_res            = tsvft_pkg::t_result'(w_res_q);
    assign o_status.stopped = !w_running;
    assign o_status.header  = w_header;

endmodule

`default_nettype wire

### rtl/tsv_row_field_tokenizer.sv
// Bytes wait in the item queue; field results wait in the result queue that drives the outputs.
// Throughput: one byte per cycle; the parser retires one queued byte each cycle.
// Input stalls (full) only when the result queue backs up into the byte queue.
// Reset (i_rst_n low at a clock edge) empties both queues and returns the parser to the header.
// ----------------------------------------------------------------------------
// tsv_row_field_tokenizer
// TSV field tokenizer: byte classifier front, row/column parser back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tsv_row_field_tokenizer_defines.svh"

module tsv_row_field_tokenizer #(
    parameter int MAX_COLUMNS = 256,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_data,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_row_number,
    output logic [7:0]       o_column_number,
    output logic [31:0]      o_field_offset,
    output logic [31:0]      o_field_length,
    output logic             o_row_done,
    output logic             o_row_accepted,
    output logic [8:0]       o_columns_per_row
);

    tsvft_pkg::t_item         w_item;
    logic                     w_item_empty;
    logic                     w_item_pop;
    tsvft_pkg::t_result       w_res;
    tsvft_pkg::t_back_status  w_status;

    tsvft_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .o_item        (w_item),
        .o_item_empty  (w_item_empty),
        .i_item_pop    (w_item_pop)
    );

    tsvft_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_empty (w_item_empty),
        .o_item_pop   (w_item_pop),
        .o_res        (w_res),
        .o_res_empty  (empty),
        .i_res_pop    (pop),
        .o_status     (w_status)
    );

    assign o_row_number      = w_res.row_number;
    assign o_column_number   = w_res.column_number;
    assign o_field_offset    = w_res.field_offset;
    assign o_field_length    = w_res.field_length;
    assign o_row_done        = w_res.row_done;
    assign o_row_accepted    = w_res.row_accepted;
    assign o_columns_per_row = w_res.columns_per_row;

    `TSVFT_ASSERT_NEXT(a_stop_sticky, w_status.stopped, w_status.stopped, "parser left stopped state")
    `TSVFT_ASSERT_NEXT(a_header_once, !w_status.header, !w_status.header, "parser reentered header")
    `TSVFT_ASSERT_NOW(a_acc_done, !empty && o_row_accepted, o_row_done, "accepted without row done")

endmodule

`default_nettype wire
